// ----- sv/pfsh_pkg.sv -----
// Package: shared types and constants of the packet field-sum histogram.
package pfsh_pkg;

  localparam int FieldOffsetW = 16;
  localparam int KeyBitsW     = 7;
  localparam int ByteW        = 8;
  localparam int BinIdxW      = 12;
  localparam int SumW         = 16;
  localparam int CountW       = 64;
  localparam int CfgIdxW      = 1;
  localparam int CfgDataW     = 16;
  localparam int MaxKeyBits   = 64;
  localparam int InDataW      = 24;

  localparam logic [ByteW-1:0]   ByteMask = 8'hFF;
  localparam logic [SumW-1:0]    PosSat   = 16'hFFFF;

  localparam logic [CfgIdxW-1:0] CfgFieldOffset = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgKeyBits     = 1'b1;

  typedef enum logic [1:0] {
    FUNC_PKT   = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_NOP   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    RES_ZERO,
    RES_READ,
    RES_COUNT
  } res_sel_e;

  typedef struct packed {
    logic     load;
    logic     pkt_step;
    logic     rd_idx;
    logic     rd_key;
    logic     incr;
    logic     clr_we;
    logic     res_load;
    res_sel_e res_sel;
    logic     out_push;
  } cmd_t;

  typedef struct packed {
    func_e func;
    logic  hit;
    logic  clr_last;
    logic  out_free;
  } sts_t;

endpackage

// ----- sv/pfsh_ctrl.sv -----
// Controller: sequences packet steps, bin reads, increments and clear sweeps.
module pfsh_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  pfsh_pkg::sts_t sts_i,
  output pfsh_pkg::cmd_t cmd_o
);
  import pfsh_pkg::*;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_CHK,
    ST_RDW,
    ST_INCR,
    ST_CLEAR,
    ST_OUT
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.res_sel = RES_ZERO;
    case (state_q)
      ST_INIT: begin
        cmd_o.clr_we = 1'b1;
        if (sts_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (sts_i.func)
          FUNC_PKT: begin
            cmd_o.pkt_step = 1'b1;
            state_d        = ST_CHK;
          end
          FUNC_READ: begin
            cmd_o.rd_idx = 1'b1;
            state_d      = ST_RDW;
          end
          FUNC_CLEAR: state_d = ST_CLEAR;
          default: begin
            cmd_o.res_load = 1'b1;
            state_d        = ST_OUT;
          end
        endcase
      end
      ST_CHK: begin
        if (sts_i.hit) begin
          cmd_o.rd_key = 1'b1;
          state_d      = ST_INCR;
        end else begin
          cmd_o.res_load = 1'b1;
          state_d        = ST_OUT;
        end
      end
      ST_RDW: begin
        cmd_o.res_load = 1'b1;
        cmd_o.res_sel  = RES_READ;
        state_d        = ST_OUT;
      end
      ST_INCR: begin
        cmd_o.incr     = 1'b1;
        cmd_o.res_load = 1'b1;
        cmd_o.res_sel  = RES_COUNT;
        state_d        = ST_OUT;
      end
      ST_CLEAR: begin
        cmd_o.clr_we = 1'b1;
        if (sts_i.clr_last) begin
          cmd_o.res_load = 1'b1;
          state_d        = ST_OUT;
        end
      end
      ST_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_push = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_INIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- sv/pfsh_datapath.sv -----
// Datapath: config, packet position and sum, bin memory and output register.
module pfsh_datapath #(
  parameter int NUM_BINS = 4096
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [pfsh_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [pfsh_pkg::CfgDataW-1:0]      cfg_data_i,
  input  logic [1:0]                         in_func_i,
  input  logic [pfsh_pkg::ByteW-1:0]         in_byte_i,
  input  logic                               in_last_i,
  input  logic                               in_drop_i,
  input  logic [pfsh_pkg::BinIdxW-1:0]       in_idx_i,
  input  logic                               out_ready_i,
  output logic                               out_valid_o,
  output logic [pfsh_pkg::CountW-1:0]        out_count_o,
  output logic                               out_counted_o,
  input  pfsh_pkg::cmd_t                     cmd_i,
  output pfsh_pkg::sts_t                     sts_o
);
  import pfsh_pkg::*;

  localparam int BinAw = $clog2(NUM_BINS);
  localparam logic [KeyBitsW-1:0] MaxKb =
    (MaxKeyBits > 127) ? 7'd127 : KeyBitsW'(MaxKeyBits);
  localparam logic [BinAw-1:0] ClrLast = BinAw'(NUM_BINS - 1);
  localparam logic [SumW:0]    NumBinsW = (SumW + 1)'(NUM_BINS);

  logic [FieldOffsetW-1:0] field_offset_q;
  logic [KeyBitsW-1:0]     key_bits_q;

  func_e             func_q;
  logic [ByteW-1:0]  byte_q;
  logic              last_q;
  logic              drop_q;
  logic [BinIdxW-1:0] idx_q;
  logic              rng_q;

  logic [SumW-1:0]   pos_q;
  logic [SumW-1:0]   sum_q;
  logic              hit_q;
  logic [BinAw-1:0]  key_q;
  logic [BinAw-1:0]  clr_q;

  logic [CountW-1:0] bins_q [NUM_BINS];
  logic [CountW-1:0] rdata_q;

  logic [CountW-1:0] res_count_q;
  logic              res_counted_q;
  logic              out_valid_q;
  logic [CountW-1:0] out_count_q;
  logic              out_counted_q;

  // key field geometry
  logic [KeyBitsW-1:0] kb;
  logic [3:0]          whole;
  logic [2:0]          left;
  logic [SumW:0]       trail;
  logic [SumW:0]       pos_x;
  logic [15:0]         mask_w;
  logic [ByteW-1:0]    add_val;
  logic [SumW-1:0]     sum_new;
  logic                sat;
  logic                reached;
  logic                hit_d;

  always_comb begin
    kb      = (key_bits_q > MaxKb) ? MaxKb : key_bits_q;
    whole   = kb[6:3];
    left    = kb[2:0];
    trail   = {1'b0, field_offset_q} + (SumW + 1)'(whole);
    pos_x   = {1'b0, pos_q};
    sat     = (pos_q == PosSat);
    mask_w  = {8'h00, ByteMask} << (4'd8 - {1'b0, left});
    add_val = '0;
    if (!sat) begin
      if ((pos_q >= field_offset_q) && (pos_x < trail)) begin
        add_val = byte_q;
      end else if (pos_x == trail) begin
        add_val = byte_q & mask_w[7:0];
      end
    end
    sum_new = sum_q + SumW'(add_val);
    reached = (trail < {1'b0, PosSat}) && !sat && (pos_x >= trail);
    hit_d   = last_q && !drop_q && reached && ({1'b0, sum_new} < NumBinsW);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_offset_q <= '0;
      key_bits_q     <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CfgFieldOffset) field_offset_q <= cfg_data_i;
      if (cfg_idx_i == CfgKeyBits)     key_bits_q     <= cfg_data_i[KeyBitsW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      func_q <= FUNC_NOP;
      pos_q  <= '0;
      sum_q  <= '0;
      hit_q  <= 1'b0;
      clr_q  <= '0;
    end else begin
      if (cmd_i.load) func_q <= func_e'(in_func_i);
      if (cmd_i.pkt_step) begin
        hit_q <= hit_d;
        if (last_q) begin
          pos_q <= '0;
          sum_q <= '0;
        end else begin
          sum_q <= sum_new;
          if (!sat) pos_q <= pos_q + 1'b1;
        end
      end
      if (cmd_i.clr_we) clr_q <= (clr_q == ClrLast) ? '0 : clr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      byte_q <= in_byte_i;
      last_q <= in_last_i;
      drop_q <= in_drop_i;
      idx_q  <= in_idx_i;
      rng_q  <= (32'(in_idx_i) < NUM_BINS);
    end
    if (cmd_i.pkt_step) key_q <= BinAw'(sum_new);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_we) begin
      bins_q[clr_q] <= '0;
    end else if (cmd_i.incr) begin
      bins_q[key_q] <= rdata_q + 1'b1;
    end
    if (cmd_i.rd_key) begin
      rdata_q <= bins_q[key_q];
    end else if (cmd_i.rd_idx) begin
      rdata_q <= bins_q[BinAw'(idx_q)];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      case (cmd_i.res_sel)
        RES_READ: begin
          res_count_q   <= rng_q ? rdata_q : '0;
          res_counted_q <= 1'b0;
        end
        RES_COUNT: begin
          res_count_q   <= '0;
          res_counted_q <= 1'b1;
        end
        default: begin
          res_count_q   <= '0;
          res_counted_q <= 1'b0;
        end
      endcase
    end
    if (cmd_i.out_push) begin
      out_count_q   <= res_count_q;
      out_counted_q <= res_counted_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_push) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_count_o   = out_count_q;
  assign out_counted_o = out_counted_q;

  assign sts_o.func     = func_q;
  assign sts_o.hit      = hit_q;
  assign sts_o.clr_last = (clr_q == ClrLast);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

endmodule

// ----- sv/packet_field_sum_histogram_top.sv -----
// Top level: packet field-sum histogram with stream ports and config writes.
// Per item: a packet byte steps ST_EXEC, ST_CHK, plus ST_INCR when a bin
// increments (memory read then write); bin read ST_EXEC and ST_RDW;
// unknown kind ST_EXEC; clear ST_EXEC, ST_CLEAR; each then ends in ST_OUT.
// One at a time, next accept once the result is pushed; stalls hold ST_OUT.
// Reset is asynchronous active low; then a clearing pass over all NUM_BINS
// bins runs with s_axis_tready low; config writes are taken throughout.
module packet_field_sum_histogram_top #(
  parameter int NUM_BINS = 4096
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pfsh_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [pfsh_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [7:0] pkt_byte, [8] drop_mark, [20:9] bin_index, [23:21] zero
  input  logic [pfsh_pkg::InDataW-1:0]  s_axis_tdata,
  // [1:0] func
  input  logic [1:0]                    s_axis_tuser,
  input  logic                          s_axis_tlast,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [63:0] bin_count
  output logic [pfsh_pkg::CountW-1:0]   m_axis_tdata,
  // [0] counted
  output logic                          m_axis_tuser
);
  import pfsh_pkg::*;

  cmd_t cmd;
  sts_t sts;

  pfsh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pfsh_datapath #(
    .NUM_BINS (NUM_BINS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_func_i     (s_axis_tuser),
    .in_byte_i     (s_axis_tdata[7:0]),
    .in_last_i     (s_axis_tlast),
    .in_drop_i     (s_axis_tdata[8]),
    .in_idx_i      (s_axis_tdata[20:9]),
    .out_ready_i   (m_axis_tready),
    .out_valid_o   (m_axis_tvalid),
    .out_count_o   (m_axis_tdata),
    .out_counted_o (m_axis_tuser),
    .cmd_i         (cmd),
    .sts_o         (sts)
  );

endmodule

// ----- sv/pfsh_checker.sv -----
// Checker: port-level assertions for the packet field-sum histogram.
module pfsh_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [pfsh_pkg::CountW-1:0]   m_axis_tdata,
  input logic                          m_axis_tuser
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // a counted packet carries no bin count
  a_counted_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("counted result with nonzero count");

  // one item in flight: no accept right after an accept
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted back to back");

  // a new result needs processing: s_axis_tready was low before it rose
  a_res_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result appeared without processing");

endmodule

bind packet_field_sum_histogram_top pfsh_checker u_pfsh_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
